// ===== src/lisc_pkg.sv =====
// shared types, codes and constants of the leveled interrupt status controller
`timescale 1ns / 1ps
`default_nettype none

package lisc_pkg;

    localparam int DATA_W     = 32;
    localparam int NUM_GROUPS = 3;
    localparam int NUM_LEVELS = 3;
    localparam int NUM_MASKS  = NUM_GROUPS * NUM_LEVELS;
    localparam int MASK_IDX_W = $clog2(NUM_MASKS);

    typedef enum logic [1:0] {
        CMD_RAISE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // status group codes
    localparam logic [1:0] GRP_NRM = 2'd0;
    localparam logic [1:0] GRP_EXT = 2'd1;
    localparam logic [1:0] GRP_ERR = 2'd2;

    // register select codes
    localparam logic [3:0] SEL_NRM        = 4'd0;
    localparam logic [3:0] SEL_EXT        = 4'd1;
    localparam logic [3:0] SEL_ERR        = 4'd2;
    localparam logic [3:0] SEL_MASK_FIRST = 4'd3;
    localparam logic [3:0] SEL_MASK_LAST  = 4'd11;

    // normal status read view
    localparam logic [DATA_W-1:0] NRM_VIS_MASK = 32'h3fff_ffff;
    localparam logic [DATA_W-1:0] EXT_SUM_BIT  = 32'h4000_0000;
    localparam logic [DATA_W-1:0] ERR_SUM_BIT  = 32'h8000_0000;

    typedef struct packed {
        cmd_t              cmd;
        logic [1:0]        int_group;
        logic [DATA_W-1:0] irq_bits;
        logic [3:0]        reg_select;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              level2_irq;
        logic              level4_irq;
        logic              level6_irq;
    } rsp_t;

    // status and masks; mask index = level * NUM_GROUPS + group
    typedef struct packed {
        logic [DATA_W-1:0]                nrm;
        logic [DATA_W-1:0]                ext;
        logic [DATA_W-1:0]                err;
        logic [NUM_MASKS-1:0][DATA_W-1:0] masks;
    } irq_state_t;

endpackage

`default_nettype wire

// ===== src/lisc_stream_if.sv =====
// valid/ready channels for requests and responses
`timescale 1ns / 1ps
`default_nettype none

interface lisc_req_if
    import lisc_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lisc_rsp_if
    import lisc_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/lisc_regfile.sv =====
// status and mask registers with event and bus update logic and read mux
`timescale 1ns / 1ps
`default_nettype none

module lisc_regfile
    import lisc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire req_t              item,
    output irq_state_t             state_next,
    output irq_state_t             state_cur,
    output logic [DATA_W-1:0]      read_data
);

    irq_state_t             state_reg;
    logic [MASK_IDX_W-1:0]  mask_idx;
    logic                   sel_is_mask;
    logic [DATA_W-1:0]      rd_mux;

    assign state_cur   = state_reg;
    assign sel_is_mask = (item.reg_select >= SEL_MASK_FIRST) &&
                         (item.reg_select <= SEL_MASK_LAST);
    assign mask_idx    = MASK_IDX_W'(item.reg_select - SEL_MASK_FIRST);

    always_comb
    begin
        state_next = state_reg;
        unique case (item.cmd)
            CMD_RAISE:
            begin
                unique case (item.int_group)
                    GRP_NRM: state_next.nrm = state_reg.nrm | item.irq_bits;
                    GRP_EXT: state_next.ext = state_reg.ext | item.irq_bits;
                    GRP_ERR: state_next.err = state_reg.err | item.irq_bits;
                    default: ;
                endcase
            end
            CMD_CLEAR:
            begin
                unique case (item.int_group)
                    GRP_NRM: state_next.nrm = state_reg.nrm & ~item.irq_bits;
                    GRP_EXT: state_next.ext = state_reg.ext & ~item.irq_bits;
                    GRP_ERR: state_next.err = state_reg.err & ~item.irq_bits;
                    default: ;
                endcase
            end
            CMD_WRITE:
            begin
                // write-one-to-clear on status, external status is read only
                if (item.reg_select == SEL_NRM)
                begin
                    state_next.nrm = state_reg.nrm & ~item.write_data;
                end
                else if (item.reg_select == SEL_ERR)
                begin
                    state_next.err = state_reg.err & ~item.write_data;
                end
                else if (sel_is_mask)
                begin
                    state_next.masks[mask_idx] = item.write_data;
                end
            end
            CMD_READ: ;
            default: ;
        endcase
    end

    always_comb
    begin
        rd_mux = '0;
        if (item.reg_select == SEL_NRM)
        begin
            rd_mux = (state_reg.nrm & NRM_VIS_MASK)
                   | ((state_reg.ext != '0) ? EXT_SUM_BIT : '0)
                   | ((state_reg.err != '0) ? ERR_SUM_BIT : '0);
        end
        else if (item.reg_select == SEL_EXT)
        begin
            rd_mux = state_reg.ext;
        end
        else if (item.reg_select == SEL_ERR)
        begin
            rd_mux = state_reg.err;
        end
        else if (sel_is_mask)
        begin
            rd_mux = state_reg.masks[mask_idx];
        end
    end

    assign read_data = (item.cmd == CMD_READ) ? rd_mux : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (en)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/lisc_level_eval.sv =====
// per-level masked status reduction
`timescale 1ns / 1ps
`default_nettype none

module lisc_level_eval
    import lisc_pkg::*;
(
    input  wire irq_state_t       state,
    output logic [NUM_LEVELS-1:0] level_irq
);

    for (genvar lvl = 0; lvl < NUM_LEVELS; lvl++)
    begin : g_level
        assign level_irq[lvl] =
            |((state.nrm & state.masks[lvl * NUM_GROUPS + int'(GRP_NRM)]) |
              (state.ext & state.masks[lvl * NUM_GROUPS + int'(GRP_EXT)]) |
              (state.err & state.masks[lvl * NUM_GROUPS + int'(GRP_ERR)]));
    end

endmodule

`default_nettype wire

// ===== src/leveled_interrupt_status_controller.sv =====
// top level of the leveled interrupt status controller
`timescale 1ns / 1ps
`default_nettype none

// Interrupt status controller with normal, external and error status groups
// and nine mask registers, three per output level (2, 4, 6). Every request
// transfer carries one command: raise or clear event bits in a group, a bus
// write (write-one-to-clear on normal and error status, ignored on external
// status, plain store on masks) or a bus read. Each request yields exactly one
// response transfer with the read data (zero for non-reads) and the three
// level lines evaluated after the request took effect. The normal status read
// shows bits 29..0 with bit 30 summarizing external and bit 31 summarizing
// error status. Each request is held in one input register; the register
// update and level reduction then feed the response register, which drives
// the response. One request can be taken every cycle, also while a response
// waits, as long as the input register drains into a free or draining
// response register. All state resets to zero.
module leveled_interrupt_status_controller
    import lisc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lisc_req_if.sink   req,
    lisc_rsp_if.source rsp
);

    // input register
    logic s1_valid_reg;
    req_t s1_item_reg;
    logic s1_adv;

    // response register
    logic out_valid_reg;
    rsp_t out_data_reg;

    irq_state_t            state_next;
    irq_state_t            state_cur;
    logic [DATA_W-1:0]     rd_data;
    logic [NUM_LEVELS-1:0] level_irq;

    // stage 1 drains whenever the response register is empty or being taken
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_item_reg <= req.data;
        end
    end

    // state only commits when the item moves into the response register
    lisc_regfile u_regfile (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (s1_adv),
        .item       (s1_item_reg),
        .state_next (state_next),
        .state_cur  (state_cur),
        .read_data  (rd_data)
    );

    // level lines use the post-update state
    lisc_level_eval u_level_eval (
        .state     (state_next),
        .level_irq (level_irq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg.read_data  <= rd_data;
            out_data_reg.level2_irq <= level_irq[0];
            out_data_reg.level4_irq <= level_irq[1];
            out_data_reg.level6_irq <= level_irq[2];
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // a pending item is never dropped from the input register
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("input register lost a pending item");

    // an empty response register always lets a request in
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("request stalled with empty response register");

    // non-read commands return zero read data
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_item_reg.cmd != CMD_READ) |=> (out_data_reg.read_data == '0))
        else $error("read data nonzero on non-read command");

    // bus commands never touch external status
    a_ext_bus: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && ((s1_item_reg.cmd == CMD_WRITE) || (s1_item_reg.cmd == CMD_READ))
        |=> $stable(state_cur.ext))
        else $error("external status changed by a bus access");

endmodule

`default_nettype wire

// ===== sim/tb_leveled_interrupt_status_controller.sv =====
// self-checking testbench of the leveled interrupt status controller
`timescale 1ns / 1ps

module tb_leveled_interrupt_status_controller;
    import lisc_pkg::*;

    // directed rows plus random requests; the last part runs without idling
    localparam int RANDOM_ITEMS = 2000;
    localparam int TAIL_ITEMS   = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam rsp_t QUIET_RSP  = '0;

    typedef struct {
        req_t item;
        bit   has_lit;
        rsp_t lit;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lisc_req_if req_ch ();
    lisc_rsp_if rsp_ch ();

    leveled_interrupt_status_controller u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted register file of the block
    logic [DATA_W-1:0] pred_nrm;
    logic [DATA_W-1:0] pred_ext;
    logic [DATA_W-1:0] pred_err;
    logic [DATA_W-1:0] pred_masks [NUM_MASKS];

    // responses still owed by the block, oldest first
    rsp_t      owed_rsps [$];
    stim_row_t dir_rows  [$];
    rsp_t      got_rsp;
    rsp_t      want_rsp;

    int  err_count;
    int  rsp_count;
    int  cmd_count [4];
    int  level_high [3];
    bit  tail_phase;

    // clock, 4 ns period
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // any status bit of a group that is enabled by the level's mask for that group
    function automatic logic level_hit(int lvl);
        logic [DATA_W-1:0] hit;
        hit = (pred_nrm & pred_masks[lvl * NUM_GROUPS + GRP_NRM])
            | (pred_ext & pred_masks[lvl * NUM_GROUPS + GRP_EXT])
            | (pred_err & pred_masks[lvl * NUM_GROUPS + GRP_ERR]);
        return |hit;
    endfunction

    // apply one request to the predicted registers and return the response it causes
    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        o = '0;
        case (r.cmd)
            CMD_RAISE:
            begin
                // the unused fourth group code changes nothing
                case (r.int_group)
                    GRP_NRM: pred_nrm |= r.irq_bits;
                    GRP_EXT: pred_ext |= r.irq_bits;
                    GRP_ERR: pred_err |= r.irq_bits;
                    default: ;
                endcase
            end
            CMD_CLEAR:
            begin
                case (r.int_group)
                    GRP_NRM: pred_nrm &= ~r.irq_bits;
                    GRP_EXT: pred_ext &= ~r.irq_bits;
                    GRP_ERR: pred_err &= ~r.irq_bits;
                    default: ;
                endcase
            end
            CMD_WRITE:
            begin
                // write-one-to-clear on normal and error, external is read-only
                if (r.reg_select == SEL_NRM)
                    pred_nrm &= ~r.write_data;
                else if (r.reg_select == SEL_ERR)
                    pred_err &= ~r.write_data;
                else if (r.reg_select >= SEL_MASK_FIRST && r.reg_select <= SEL_MASK_LAST)
                    pred_masks[r.reg_select - SEL_MASK_FIRST] = r.write_data;
            end
            default:
            begin
                if (r.reg_select == SEL_NRM)
                begin
                    // top two bits are summaries, stored top bits stay hidden
                    o.read_data = pred_nrm & NRM_VIS_MASK;
                    if (pred_ext != '0)
                        o.read_data |= EXT_SUM_BIT;
                    if (pred_err != '0)
                        o.read_data |= ERR_SUM_BIT;
                end
                else if (r.reg_select == SEL_EXT)
                    o.read_data = pred_ext;
                else if (r.reg_select == SEL_ERR)
                    o.read_data = pred_err;
                else if (r.reg_select >= SEL_MASK_FIRST && r.reg_select <= SEL_MASK_LAST)
                    o.read_data = pred_masks[r.reg_select - SEL_MASK_FIRST];
            end
        endcase
        // levels are evaluated after the request took effect
        o.level2_irq = level_hit(0);
        o.level4_irq = level_hit(1);
        o.level6_irq = level_hit(2);
        return o;
    endfunction

    function automatic req_t mk_req(cmd_t c, logic [1:0] g, logic [DATA_W-1:0] b,
                                    logic [3:0] s, logic [DATA_W-1:0] d);
        req_t r;
        r.cmd        = c;
        r.int_group  = g;
        r.irq_bits   = b;
        r.reg_select = s;
        r.write_data = d;
        return r;
    endfunction

    // data words: dense, one-hot, extremes, sparse, and patterns on the hidden top bits
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h1 << $urandom_range(0, 31);
            2: return '1;
            3: return '0;
            4: return $urandom & $urandom & $urandom;
            default: return 32'h3 << $urandom_range(28, 30);
        endcase
    endfunction

    function automatic req_t rand_request();
        logic [1:0] g;
        logic [3:0] s;
        // mostly legal group and register codes, sometimes the unused ones
        g = ($urandom_range(0, 9) != 0) ? 2'($urandom_range(0, 2)) : 2'd3;
        s = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 11))
                                         : 4'($urandom_range(12, 15));
        return mk_req(cmd_t'($urandom_range(0, 3)), g, rand_word(), s, rand_word());
    endfunction

    task automatic add_row(req_t it, bit has_lit, rsp_t lit);
        stim_row_t row;
        row.item    = it;
        row.has_lit = has_lit;
        row.lit     = lit;
        dir_rows.push_back(row);
    endtask

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        err_count++;
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // holds valid until the transfer happens, then records what it must cause
    task automatic send_item(req_t it, bit has_lit, rsp_t lit);
        rsp_t pred;
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // predictor runs on every transfer so its registers follow the block
        pred = apply_request(it);
        owed_rsps.push_back(has_lit ? lit : pred);
        cmd_count[it.cmd]++;
    endtask

    // random idle bursts between requests, with calm stretches and none in the tail
    task automatic maybe_pause(bit calm);
        if (!tail_phase && !calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7))
                @(posedge clk);
        end
    endtask

    // response side: stall in random bursts, with stretches that never stall and none in the tail
    initial
    begin
        int  stall_left;
        bit  calm;
        stall_left   = 0;
        calm         = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) == 0)
                calm = ~calm;
            if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!tail_phase && !calm && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 7);
            end
        end
    end

    // response checker: every response transfer must match the oldest owed response
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_rsp = rsp_ch.data;
            rsp_count++;
            level_high[0] += got_rsp.level2_irq;
            level_high[1] += got_rsp.level4_irq;
            level_high[2] += got_rsp.level6_irq;
            if (owed_rsps.size() == 0)
            begin
                report_mismatch("unexpected response", got_rsp.read_data, '0);
            end
            else
            begin
                want_rsp = owed_rsps.pop_front();
                if (got_rsp.read_data !== want_rsp.read_data)
                    report_mismatch("read_data", got_rsp.read_data, want_rsp.read_data);
                if (got_rsp.level2_irq !== want_rsp.level2_irq)
                    report_mismatch("level2_irq", 32'(got_rsp.level2_irq),
                                    32'(want_rsp.level2_irq));
                if (got_rsp.level4_irq !== want_rsp.level4_irq)
                    report_mismatch("level4_irq", 32'(got_rsp.level4_irq),
                                    32'(want_rsp.level4_irq));
                if (got_rsp.level6_irq !== want_rsp.level6_irq)
                    report_mismatch("level6_irq", 32'(got_rsp.level6_irq),
                                    32'(want_rsp.level6_irq));
            end
        end
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout: %0d responses still owed", owed_rsps.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // main sequence
    initial
    begin
        bit calm_tx;
        err_count    = 0;
        rsp_count    = 0;
        tail_phase   = 1'b0;
        calm_tx      = 1'b0;
        cmd_count    = '{default: 0};
        level_high   = '{default: 0};
        pred_nrm     = '0;
        pred_ext     = '0;
        pred_err     = '0;
        pred_masks   = '{default: '0};
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;

        // directed rows; literal responses only where they are obvious
        // everything reads zero after reset, including the unused register codes
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_NRM, '0), 1'b1, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_EXT, '0), 1'b1, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_ERR, '0), 1'b1, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_MASK_LAST, '0), 1'b1, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, 4'hf, '0), 1'b1, QUIET_RSP);
        // writes above the last mask and events on the fourth group are dropped
        add_row(mk_req(CMD_WRITE, GRP_NRM, '0, 4'hf, '1), 1'b1, QUIET_RSP);
        add_row(mk_req(CMD_RAISE, 2'd3, '1, SEL_NRM, '0), 1'b1, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_NRM, '0), 1'b1, QUIET_RSP);
        // all normal bits set but every mask is zero, so no level fires
        add_row(mk_req(CMD_RAISE, GRP_NRM, '1, SEL_NRM, '0), 1'b1, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_NRM, '0), 1'b1,
                rsp_t'{NRM_VIS_MASK, 1'b0, 1'b0, 1'b0});
        // hidden top bits of normal status still drive level 2
        add_row(mk_req(CMD_WRITE, GRP_NRM, '0, SEL_MASK_FIRST, 32'hc000_0000), 1'b1,
                rsp_t'{32'h0, 1'b1, 1'b0, 1'b0});
        add_row(mk_req(CMD_WRITE, GRP_NRM, '0, SEL_NRM, NRM_VIS_MASK), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_NRM, '0), 1'b0, QUIET_RSP);
        // external summary bit, and a status write to external that is ignored
        add_row(mk_req(CMD_RAISE, GRP_EXT, 32'h1, SEL_NRM, '0), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_WRITE, GRP_NRM, '0, SEL_EXT, '1), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_NRM, '0), 1'b0, QUIET_RSP);
        // error summary bit and the higher levels
        add_row(mk_req(CMD_RAISE, GRP_ERR, ERR_SUM_BIT, SEL_NRM, '0), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_NRM, '0), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_WRITE, GRP_NRM, '0, SEL_MASK_LAST, '1), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_WRITE, GRP_NRM, '0, 4'd7, 32'h1), 1'b0, QUIET_RSP);
        // clearing by event and by bus write
        add_row(mk_req(CMD_CLEAR, 2'd3, '1, SEL_NRM, '0), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_CLEAR, GRP_EXT, '1, SEL_NRM, '0), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_WRITE, GRP_NRM, '0, SEL_ERR, '1), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_CLEAR, GRP_NRM, '1, SEL_NRM, '0), 1'b0, QUIET_RSP);
        add_row(mk_req(CMD_READ,  GRP_NRM, '0, SEL_MASK_LAST, '0), 1'b0, QUIET_RSP);

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].item, dir_rows[i].has_lit, dir_rows[i].lit);
            maybe_pause(1'b0);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            // hold off once until the block has answered everything
            if (n == RANDOM_ITEMS / 2)
            begin
                req_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (owed_rsps.size() != 0);
            end
            if ($urandom_range(0, 63) == 0)
                calm_tx = ~calm_tx;
            send_item(rand_request(), 1'b0, QUIET_RSP);
            maybe_pause(calm_tx);
        end
        req_ch.valid <= 1'b0;

        // drain, then a few more cycles to catch stray responses
        while (owed_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d raise, %0d clear, %0d write, %0d read transfers, %0d responses",
                 cmd_count[CMD_RAISE], cmd_count[CMD_CLEAR], cmd_count[CMD_WRITE],
                 cmd_count[CMD_READ], rsp_count);
        $display("levels 2/4/6 seen high in %0d/%0d/%0d responses, %0d mismatches",
                 level_high[0], level_high[1], level_high[2], err_count);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
